// ===== src/rmir_pkg.sv =====
// shared types and constants for the running median block
`timescale 1ns / 1ps

package rmir_pkg;

   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // per-request control broadcast to every cell
   typedef struct packed {
      logic op_remove;
      logic ins_en;
      logic rem_en;
   } cell_ctrl_type;

endpackage

// ===== src/rmir_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps

interface rmir_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [VALUE_WIDTH-1:0] sample_value;

   modport source (output valid, output req_type, output sample_value, input ready);
   modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

interface rmir_rsp_if #(
   parameter int VALUE_WIDTH = 32
);
   import rmir_pkg::*;
   localparam int MED_W = (VALUE_WIDTH >= 64) ? 64 : VALUE_WIDTH + 1;

   logic                     valid;
   logic                     ready;
   logic signed [MED_W-1:0]  median_times_two;
   logic                     median_valid;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_OUT_W-1:0]   element_count;

   modport source (output valid, output median_times_two, output median_valid,
                   output status, output element_count, input ready);
   modport sink   (input valid, input median_times_two, input median_valid,
                   input status, input element_count, output ready);
endinterface

// ===== src/rmir_cell.sv =====
// one slot of the sorted store with its neighbor shift logic
`timescale 1ns / 1ps

module rmir_cell import rmir_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [VALUE_WIDTH-1:0] sample,
   input  logic                          in_range,
   input  logic                          prev_flag,
   input  logic signed [VALUE_WIDTH-1:0] prev_value,
   input  logic signed [VALUE_WIDTH-1:0] next_value,
   output logic                          flag,
   output logic                          hit,
   output logic signed [VALUE_WIDTH-1:0] value
);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          less;
   logic                          first;

   assign less  = sample < value_ff;
   // flag marks this slot at or past the insert or remove point
   assign flag  = in_range ? (ctrl.op_remove ? (sample <= value_ff) : less) : 1'b1;
   assign first = flag && !prev_flag;
   assign hit   = first && in_range && (sample == value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (flag) begin
         if (ctrl.ins_en) begin
            value_in = first ? sample : prev_value;
         end else if (ctrl.rem_en) begin
            value_in = next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/running_median_insert_remove.sv =====
// running median over a sorted chain of sample cells
`timescale 1ns / 1ps

// usage:
//  - req_ch carries one request: req_type (insert or remove) and a signed
//    sample_value; it is taken when valid and ready are both high
//  - rsp_ch returns one response per request: twice the median, a valid
//    flag, a status (done, full, not found) and the sample count after it
//  - the samples live in a row of DEPTH cells kept in ascending order; at
//    the accept edge every cell compares the sample with its own value and
//    shifts from its lower or upper neighbor, so the store updates at that
//    edge regardless of where the sample lands
//  - the cycle after, the two middle cells are selected by count and added
//  - the response is offered in ST_OUT, after ST_SELECT; one request is in
//    flight at a time, so a new request waits out any response stall
//  - req_ch.ready stays low while a response waits on rsp_ch.ready
//  - reset empties the set (count zero); cell contents are not cleared since
//    only slots below the count ever reach the response
//  - payload widths follow VALUE_WIDTH of the channel interfaces

module running_median_insert_remove import rmir_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   rmir_req_if.sink    req_ch,
   rmir_rsp_if.source  rsp_ch
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int MED_W = (VALUE_WIDTH >= 64) ? 64 : VALUE_WIDTH + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_OUT
   } state_type;

   state_type                     state_ff;
   logic [CW-1:0]                 count_ff;
   status_type                    status_ff;
   logic signed [MED_W-1:0]       median_ff;
   logic                          med_valid_ff;

   logic signed [VALUE_WIDTH-1:0] sample;
   logic                          accept;
   logic                          full;
   logic                          found;
   cell_ctrl_type                 ctrl;

   logic [DEPTH-1:0]              flag_vec;
   logic [DEPTH-1:0]              hit_vec;
   logic [DEPTH-1:0]              range_vec;
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];

   logic [CW-1:0]                 lo_idx, hi_idx;
   logic signed [VALUE_WIDTH:0]   median_sum;
   logic [CW+COUNT_OUT_W-1:0]     count_ext;

   assign sample = req_ch.sample_value;
   assign accept = req_ch.valid && req_ch.ready;
   assign full   = count_ff == CW'(DEPTH);
   // a remove succeeds only when the first slot at or above the sample matches
   assign found  = |hit_vec;

   assign ctrl.op_remove = req_ch.req_type == REQ_REMOVE;
   assign ctrl.ins_en    = accept && (req_ch.req_type == REQ_INSERT) && !full;
   assign ctrl.rem_en    = accept && (req_ch.req_type == REQ_REMOVE) && found;

   // the cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign range_vec[i] = CW'(i) < count_ff;

      rmir_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sample     (sample),
         .in_range   (range_vec[i]),
         .prev_flag  ((i == 0) ? 1'b0 : flag_vec[(i == 0) ? 0 : i - 1]),
         .prev_value (cell_value[(i == 0) ? 0 : i - 1]),
         .next_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
         .flag       (flag_vec[i]),
         .hit        (hit_vec[i]),
         .value      (cell_value[i])
      );
   end

   // middle slots: equal for an odd count, adjacent for an even one
   assign lo_idx     = (count_ff - CW'(1)) >> 1;
   assign hi_idx     = count_ff >> 1;
   assign median_sum = {cell_value[lo_idx[IW-1:0]][VALUE_WIDTH-1], cell_value[lo_idx[IW-1:0]]}
                     + {cell_value[hi_idx[IW-1:0]][VALUE_WIDTH-1], cell_value[hi_idx[IW-1:0]]};

   assign count_ext  = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         status_ff    <= STATUS_DONE;
         med_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff  <= ST_SELECT;
                  status_ff <= STATUS_DONE;
                  if (req_ch.req_type == REQ_INSERT) begin
                     if (full) begin
                        status_ff <= STATUS_FULL;
                     end else begin
                        count_ff <= count_ff + CW'(1);
                     end
                  end else begin
                     if (found) begin
                        count_ff <= count_ff - CW'(1);
                     end else begin
                        status_ff <= STATUS_NOT_FOUND;
                     end
                  end
               end
            end
            ST_SELECT: begin
               med_valid_ff <= count_ff != '0;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // response payload, loaded once the store has settled
   always_ff @(posedge clock) begin
      if (state_ff == ST_SELECT) begin
         median_ff <= (count_ff != '0) ? median_sum[MED_W-1:0] : '0;
      end
   end

   assign req_ch.ready            = state_ff == ST_IDLE;
   assign rsp_ch.valid            = state_ff == ST_OUT;
   assign rsp_ch.median_times_two = median_ff;
   assign rsp_ch.median_valid     = med_valid_ff;
   assign rsp_ch.status           = status_ff;
   assign rsp_ch.element_count    = count_ext[COUNT_OUT_W-1:0];

endmodule

// ===== src/rmir_checker.sv =====
// port-level checks for the running median block and their bind
`timescale 1ns / 1ps

module rmir_checker import rmir_pkg::*; #(
   parameter int DEPTH = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   median_valid,
   input logic [STATUS_W-1:0]    status,
   input logic [COUNT_OUT_W-1:0] element_count
);

   localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(DEPTH);

   // a pending response holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // no new request while a response is outstanding
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   // valid flag tracks a non-empty set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (median_valid == (element_count != '0)))
      else $error("median valid flag disagrees with the count");

   // a full rejection only comes from a full store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STATUS_FULL) |-> (element_count == DEPTH_OUT))
      else $error("full status with the store not full");

   // an accepted request yields a response once the block has selected the median
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("response missing after request");

endmodule

bind running_median_insert_remove rmir_checker #(
   .DEPTH (DEPTH)
) u_rmir_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .median_valid  (rsp_ch.median_valid),
   .status        (rsp_ch.status),
   .element_count (rsp_ch.element_count)
);
